// ===== rtl/core/stiu_pkg.sv =====
// ----------------------------------------------------------------------------
// stiu_pkg
// Shared types and constants for the sorted table insert/update block.
// ----------------------------------------------------------------------------
package stiu_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_W           = 32;
  localparam int TYPE_W          = 8;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 6;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 6;
  localparam int DEV_LSB         = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd63;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 2'd0,
    ST_APPENDED = 2'd1,
    ST_INSERTED = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] tag;
    logic [DATA_W-1:0] data;
  } entry_t;

  localparam int ENTRY_W = KEY_W + TYPE_W + DATA_W;

endpackage

// ===== rtl/core/sorted_table_insert_update.sv =====
// From the accepting edge to out_valid: a reject goes straight to the result stage, an update
// searches up to its slot, an append searches all entries in use and an insert also shifts
// the entries above its slot; a result held by out_ready low holds the block as well.
// Throughput: one word at a time, in_ready returns with out_valid; the single table
// RAM sets the rate, one read per slot searched, one read and one write per slot shifted.
// Reset: clears the entry count and sets capacity to 63; the RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_table_insert_update
// Table kept sorted by key bits 31:8 with add-or-update of one word at a time.
// ----------------------------------------------------------------------------
module sorted_table_insert_update #(
  parameter int TABLE_DEPTH = stiu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [stiu_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stiu_pkg::KEY_W-1:0]    in_entry_key,
  input  logic [stiu_pkg::TYPE_W-1:0]   in_entry_type,
  input  logic [stiu_pkg::DATA_W-1:0]   in_entry_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stiu_pkg::STATUS_W-1:0] out_status,
  output logic [stiu_pkg::COUNT_W-1:0]  out_used_count
);
  import stiu_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH);

  logic [CAP_W-1:0]   capacity_r;
  logic               ram_we, ram_re;
  logic [CW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  stiu_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .capacity       (capacity_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_key   (in_entry_key),
    .in_entry_type  (in_entry_type),
    .in_entry_data  (in_entry_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_used_count (out_used_count),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  stiu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/stiu_ram.sv =====
// ----------------------------------------------------------------------------
// stiu_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stiu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/stiu_seq.sv =====
// ----------------------------------------------------------------------------
// stiu_seq
// Sequencer: linear search with one shared compare, shift-up insertion
// through the table RAM, and the result register.
// ----------------------------------------------------------------------------
module stiu_seq #(
  parameter int TABLE_DEPTH = stiu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [stiu_pkg::CAP_W-1:0]     capacity,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [stiu_pkg::KEY_W-1:0]     in_entry_key,
  input  logic [stiu_pkg::TYPE_W-1:0]    in_entry_type,
  input  logic [stiu_pkg::DATA_W-1:0]    in_entry_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stiu_pkg::STATUS_W-1:0]  out_status,
  output logic [stiu_pkg::COUNT_W-1:0]   out_used_count,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [stiu_pkg::ENTRY_W-1:0]   ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [stiu_pkg::ENTRY_W-1:0]   ram_rdata
);
  import stiu_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  logic [DATA_W-1:0]   data_r, data_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  status_t             status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [LW-1:0]       cap_ext, dmax, limit, used_ext;
  logic                full;
  entry_t              rd_entry, item;
  logic [KEY_W-DEV_LSB-1:0] dev_slot, dev_item;
  logic                slot_lt, slot_eq;

  assign cap_ext  = LW'(capacity);
  assign dmax     = LW'(TABLE_DEPTH - 1);
  assign limit    = (cap_ext < dmax) ? cap_ext : dmax;
  assign used_ext = LW'(used_r);
  assign full     = (used_ext >= limit);

  assign rd_entry = entry_t'(ram_rdata);
  assign item     = '{key: key_r, tag: type_r, data: data_r};
  assign dev_slot = rd_entry.key[KEY_W-1:DEV_LSB];
  assign dev_item = key_r[KEY_W-1:DEV_LSB];
  assign slot_lt  = (dev_slot < dev_item);
  assign slot_eq  = (dev_slot == dev_item);

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_used_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    type_nxt       = type_r;
    data_nxt       = data_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    used_nxt       = used_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = item;
    ram_re         = 1'b0;
    ram_raddr      = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_entry_key;
          type_nxt = in_entry_type;
          data_nxt = in_entry_data;
          pos_nxt  = '0;
          if (in_entry_key == '0 || full) begin
            status_nxt = ST_REJECTED;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (pos_r == used_r) begin
          ram_we     = 1'b1;
          used_nxt   = used_r + 1'b1;
          status_nxt = ST_APPENDED;
          state_nxt  = S_OUT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (slot_lt) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_SRCH_RD;
        end else if (slot_eq) begin
          ram_we     = 1'b1;
          status_nxt = ST_UPDATED;
          state_nxt  = S_OUT;
        end else begin
          j_nxt     = used_r;
          state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (j_r == pos_r) begin
          ram_we     = 1'b1;
          used_nxt   = used_r + 1'b1;
          status_nxt = ST_INSERTED;
          state_nxt  = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_r - 1'b1;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = ram_rdata;
        j_nxt     = j_r - 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(used_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    type_r       <= type_nxt;
    data_r       <= data_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// ===== sim/sorted_table_insert_update_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_update_tb
// Drives add-or-update words into the sorted table and checks every result.
// A scoreboard keeps its own sorted copy of the table and the capacity and
// works out the status and entry count for each word that the block takes.
// A short directed part covers the key and field extremes, every status and
// the full, zero-capacity and below-count cases. Random phases follow, each
// after a capacity write, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_table_insert_update_tb;

  import stiu_pkg::*;

  localparam int DEPTH         = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_WORDS   = 102;

  class table_scoreboard;
    typedef struct {
      status_t           status;
      logic [COUNT_W-1:0] count;
    } table_result_t;

    logic [KEY_W-1:0]  key_at  [DEPTH];
    logic [TYPE_W-1:0] tag_at  [DEPTH];
    logic [DATA_W-1:0] data_at [DEPTH];
    int unsigned       used;
    logic [CAP_W-1:0]  capacity;
    table_result_t     pending[$];
    int unsigned       mismatches;
    int unsigned       status_seen[4];

    function new();
      used       = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_entry(logic [KEY_W-1:0] key, logic [TYPE_W-1:0] tag,
                             logic [DATA_W-1:0] data);
      int unsigned   limit;
      int unsigned   pos;
      int unsigned   j;
      table_result_t res;
      limit = capacity;
      if (limit > DEPTH - 1) limit = DEPTH - 1;
      if (key == '0 || used >= limit) begin
        res.status = ST_REJECTED;
      end else begin
        pos = 0;
        while (pos < used && key_at[pos][KEY_W-1:DEV_LSB] < key[KEY_W-1:DEV_LSB]) pos++;
        if (pos < used && key_at[pos][KEY_W-1:DEV_LSB] == key[KEY_W-1:DEV_LSB]) begin
          res.status = ST_UPDATED;
        end else begin
          res.status = (pos == used) ? ST_APPENDED : ST_INSERTED;
          for (j = used; j > pos; j--) begin
            key_at[j]  = key_at[j-1];
            tag_at[j]  = tag_at[j-1];
            data_at[j] = data_at[j-1];
          end
          used++;
        end
        key_at[pos]  = key;
        tag_at[pos]  = tag;
        data_at[pos] = data;
      end
      res.count = used[COUNT_W-1:0];
      pending.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
      table_result_t want;
      if (pending.size() == 0) begin
        $error("result with no word pending: status %0d used_count %0d", status, count);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      status_seen[want.status]++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("used_count: expected %0d, got %0d", want.count, count);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata      = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [KEY_W-1:0]    in_entry_key   = '0;
  logic [TYPE_W-1:0]   in_entry_type  = '0;
  logic [DATA_W-1:0]   in_entry_data  = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_used_count;

  table_scoreboard sb;
  bit              idle_on = 1'b1;
  int unsigned     words_sent = 0;
  int unsigned     cap_writes = 0;

  sorted_table_insert_update #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_entry_key   (in_entry_key),
    .in_entry_type  (in_entry_type),
    .in_entry_data  (in_entry_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_used_count (out_used_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_entry(in_entry_key, in_entry_type, in_entry_data);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_status, out_used_count);
    end
  end

  // stall the result side in bursts
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sorted_table_insert_update_tb failed");
    $finish;
  end

  task automatic send_word(input logic [KEY_W-1:0] key, input logic [TYPE_W-1:0] tag,
                           input logic [DATA_W-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_entry_key  <= key;
    in_entry_type <= tag;
    in_entry_data <= data;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // drop valid, then hold until every result is back
  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we      <= 1'b0;
    sb.capacity  = cap;
    cap_writes++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned         sel;
    int unsigned         idx;
    logic [KEY_W-DEV_LSB-1:0] top;
    sel = $urandom_range(0, 99);
    top = (sb.used > 0) ? sb.key_at[sb.used-1][KEY_W-1:DEV_LSB] : '0;
    if (sel < 3) begin
      return '0;
    end else if (sel < 6) begin
      return KEY_W'($urandom_range(1, 255));
    end else if (sel < 10) begin
      return $urandom();
    end else if (sel < 13 && top != '1) begin
      return {24'($urandom_range(top + 1, 24'hFFFFFF)), 8'($urandom())};
    end else if (sel < 16) begin
      return {24'($urandom_range(0, top)), 8'($urandom())};
    end else if (sb.used > 0) begin
      idx = $urandom_range(0, sb.used - 1);
      return {sb.key_at[idx][KEY_W-1:DEV_LSB], 8'($urandom())};
    end
    return $urandom();
  endfunction

  initial begin : stimulus
    int unsigned      ph;
    int unsigned      n;
    int unsigned      next_cap;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset capacity, every status, field extremes
    send_word(32'h0000_0000, 8'hFF, 32'hFFFF_FFFF);
    send_word(32'h0000_0001, 8'h00, 32'h0000_0000);
    send_word(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_word(32'h0000_00FF, 8'h5A, 32'h0000_0001);
    send_word(32'h1234_5600, 8'hA5, 32'h8000_0000);
    send_word(32'hFFFF_FF00, 8'h01, 32'h7FFF_FFFF);
    send_word(32'h0000_0100, 8'h80, 32'h5555_5555);
    wait_results();
    write_capacity(6'd4);
    send_word(32'h8000_0000, 8'h7F, 32'hAAAA_AAAA);
    send_word(32'h0000_0001, 8'h11, 32'h1111_1111);
    wait_results();
    write_capacity(6'd0);
    send_word(32'h5555_5555, 8'h22, 32'h2222_2222);
    send_word(32'h0000_0000, 8'h33, 32'h3333_3333);
    wait_results();
    write_capacity(6'd1);
    send_word(32'h1234_5678, 8'h44, 32'h4444_4444);
    wait_results();
    write_capacity(6'd63);
    send_word(32'hAAAA_AAAA, 8'h5A, 32'hA5A5_A5A5);
    send_word(32'h7FFF_FF80, 8'hC3, 32'h0F0F_0F0F);
    wait_results();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 3) begin
        next_cap = 0;
      end else if (ph == 6) begin
        next_cap = (sb.used > 1) ? $urandom_range(1, sb.used - 1) : 1;
      end else if (ph >= 12) begin
        next_cap = 63;
      end else begin
        next_cap = sb.used + $urandom_range(2, 8);
        if (next_cap > 63) next_cap = 63;
      end
      write_capacity(CAP_W'(next_cap));
      idle_on = (ph < 12) && (ph % 4 != 1);
      for (n = 0; n < PHASE_WORDS; n++) begin
        send_word(pick_key(), 8'($urandom()), $urandom());
      end
      wait_results();
    end

    repeat (2 * DEPTH + 8) @(negedge clk);
    $display("sent %0d words under %0d capacity writes; table ends with %0d entries",
             words_sent, cap_writes, sb.used);
    $display("results: %0d updated, %0d appended, %0d inserted, %0d rejected",
             sb.status_seen[ST_UPDATED], sb.status_seen[ST_APPENDED],
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_REJECTED]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("sorted_table_insert_update_tb passed");
    end else begin
      $display("sorted_table_insert_update_tb failed");
    end
    $finish;
  end

endmodule
